// ===== rtl/utf8cdv_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8cdv_pkg
// Shared types and constants for the UTF-8 character decoder / validator.
// ----------------------------------------------------------------------------
package utf8cdv_pkg;

  localparam int NUM_LANES = 4;

  localparam logic [20:0] CP_LIMIT = 21'h10FFFF;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_LEAD   = 3'd1,
    ST_SHORT      = 3'd2,
    ST_TOO_LONG   = 3'd3,
    ST_OVERLONG   = 3'd4,
    ST_SURROGATE  = 3'd5,
    ST_OVER_LIMIT = 3'd6
  } status_t;

  // what one lane reports about its byte
  typedef struct packed {
    logic       cont;
    logic [5:0] bits;
  } lane_info_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  char_length;
    status_t     status;
  } result_t;

endpackage

// ===== rtl/utf8cdv_lane.sv =====
// ----------------------------------------------------------------------------
// utf8cdv_lane
// One byte lane: continuation test and payload extraction.
// ----------------------------------------------------------------------------
module utf8cdv_lane
  import utf8cdv_pkg::*;
(
  input  logic [7:0] data,
  output lane_info_t info
);

  assign info.cont = (data[7:6] == 2'b10);
  assign info.bits = data[5:0];

endmodule

// ===== rtl/utf8cdv_merge.sv =====
// ----------------------------------------------------------------------------
// utf8cdv_merge
// Lead byte classification and merge of the lane results into one
// code point, length and status.
// ----------------------------------------------------------------------------
module utf8cdv_merge
  import utf8cdv_pkg::*;
(
  input  logic [7:0] lead,
  input  logic [7:0] second,
  input  lane_info_t lanes [1:NUM_LANES],
  output result_t    res
);

  logic [2:0]  n;
  logic [2:0]  got;
  logic [20:0] cp;
  logic        run;
  logic        too_long;

  always_comb begin
    if (!lead[7]) begin
      n = 3'd1;
    end else if (lead[7:5] == 3'b110) begin
      n = 3'd2;
    end else if (lead[7:4] == 4'b1110) begin
      n = 3'd3;
    end else if (lead[7:3] == 5'b11110) begin
      n = 3'd4;
    end else begin
      n = 3'd0;
    end
  end

  always_comb begin
    case (n)
      3'd2:    cp = {16'd0, lead[4:0]};
      3'd3:    cp = {17'd0, lead[3:0]};
      3'd4:    cp = {18'd0, lead[2:0]};
      default: cp = '0;
    endcase
    run = 1'b1;
    got = 3'd1;
    // fold continuation bytes until the first non-continuation
    for (int i = 1; i < NUM_LANES; i++) begin
      if (i < int'(n) && run && lanes[i].cont) begin
        cp  = {cp[14:0], lanes[i].bits};
        got = got + 3'd1;
      end else begin
        run = 1'b0;
      end
    end
  end

  // byte right after a complete character
  always_comb begin
    case (n)
      3'd2:    too_long = lanes[2].cont;
      3'd3:    too_long = lanes[3].cont;
      3'd4:    too_long = lanes[4].cont;
      default: too_long = 1'b0;
    endcase
  end

  always_comb begin
    res.code_point  = cp;
    res.char_length = n;
    res.status      = ST_OK;
    if (n == 3'd1) begin
      res.code_point = {13'd0, lead};
    end else if (n == 3'd0) begin
      res.code_point  = '0;
      res.char_length = 3'd1;
      res.status      = ST_BAD_LEAD;
    end else if (got < n) begin
      res.char_length = got;
      res.status      = ST_SHORT;
    end else if (too_long) begin
      res.status = ST_TOO_LONG;
    end else if (lead == 8'hC0 || lead == 8'hC1 ||
                 (lead == 8'hE0 && second < 8'hA0) ||
                 (lead == 8'hF0 && second < 8'h90)) begin
      res.status = ST_OVERLONG;
    end else if (lead == 8'hED && second >= 8'hA0) begin
      res.status = ST_SURROGATE;
    end else if (cp > CP_LIMIT) begin
      res.status = ST_OVER_LIMIT;
    end
  end

endmodule

// ===== rtl/utf8_char_decoder_validator_top.sv =====
// ----------------------------------------------------------------------------
// utf8_char_decoder_validator_top
// Decodes and validates one UTF-8 character per request from a five-byte
// window.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   in      | in_valid / in_stall | first_byte .. fifth_byte
//   out     | out_valid/out_stall | code_point, char_length, status
//
// One request per cycle sustained while out_stall is low; each result is registered.
// Four byte lanes and the merge logic are combinational ahead of the output
// register; a one-entry skid register lets a request in while a result waits.
// in_stall rises only when both the output and skid registers are full.
// rst (synchronous) clears the valid flags only.
// ----------------------------------------------------------------------------
module utf8_char_decoder_validator_top
  import utf8cdv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  first_byte,
  input  logic [7:0]  second_byte,
  input  logic [7:0]  third_byte,
  input  logic [7:0]  fourth_byte,
  input  logic [7:0]  fifth_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] code_point,
  output logic [2:0]  char_length,
  output logic [2:0]  status
);

  lane_info_t lanes [1:NUM_LANES];
  logic [7:0] lane_bytes [1:NUM_LANES];
  result_t    res_new;
  result_t    out_res;
  result_t    skid_res;
  logic       skid_valid;
  logic       accept;
  logic       take;

  assign lane_bytes[1] = second_byte;
  assign lane_bytes[2] = third_byte;
  assign lane_bytes[3] = fourth_byte;
  assign lane_bytes[4] = fifth_byte;

  for (genvar g = 1; g <= NUM_LANES; g++) begin : g_lane
    utf8cdv_lane u_lane (
      .data (lane_bytes[g]),
      .info (lanes[g])
    );
  end

  utf8cdv_merge u_merge (
    .lead   (first_byte),
    .second (second_byte),
    .lanes  (lanes),
    .res    (res_new)
  );

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign take     = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take || !out_valid) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take || !out_valid) begin
      out_res <= skid_valid ? skid_res : res_new;
    end else if (accept) begin
      skid_res <= res_new;
    end
  end

  assign code_point  = out_res.code_point;
  assign char_length = out_res.char_length;
  assign status      = out_res.status;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_length >= 3'd1 && char_length <= 3'd4))
    else $error("char_length out of range");

  a_bad_lead: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_BAD_LEAD) |-> (code_point == '0 && char_length == 3'd1))
    else $error("bad lead result malformed");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    (accept && !out_valid) |=> out_valid)
    else $error("accepted request did not reach output register");

endmodule
